FILE: rtl/core/prl_pkg.sv
// prl_pkg: shared types, codes and constants of the persistent ring log
// used by prl_regs, prl_ctrl and persistent_ring_log; depends on nothing
package prl_pkg;

  // fixed field widths
  localparam int STATUS_W = 16;
  localparam int IDX_W    = 6;
  localparam int CNT_W    = 6;
  localparam int MODE_W   = 3;

  // configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // parameter defaults
  localparam int DEF_SLOTS        = 64;
  localparam int DEF_PAYLOAD_BITS = 64;

  // register reset values
  localparam logic [STATUS_W-1:0] ACTIVE_LOW_RST  = 16'd1;
  localparam logic [STATUS_W-1:0] ACTIVE_HIGH_RST = 16'd4;

  // register indexes
  typedef enum logic {
    REG_ACTIVE_LOW  = 1'b0,
    REG_ACTIVE_HIGH = 1'b1
  } reg_idx_e;

  // operation codes
  typedef enum logic [MODE_W-1:0] {
    MODE_RECOVER   = 3'd0,
    MODE_APPEND    = 3'd1,
    MODE_OVERWRITE = 3'd2,
    MODE_READ      = 3'd3,
    MODE_WRITE     = 3'd4
  } mode_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_APPEND2,
    ST_RDWAIT,
    ST_SCAN,
    ST_SCANLAST,
    ST_SCANFIN
  } ctrl_state_e;

  // recover scan phases
  typedef enum logic [1:0] {
    PH_HEAD,
    PH_FIRST,
    PH_SECOND,
    PH_DONE
  } scan_phase_e;

  // active status window
  typedef struct packed {
    logic [STATUS_W-1:0] active_low;
    logic [STATUS_W-1:0] active_high;
  } cfg_t;

  // slot status inside the active window
  function automatic logic slot_active(logic [STATUS_W-1:0] st, cfg_t cfg);
    return (st >= cfg.active_low) && (st <= cfg.active_high);
  endfunction

endpackage

FILE: rtl/core/prl_regs.sv
// prl_regs: APB-style register file holding the active status window
// depends on prl_pkg
module prl_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [prl_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [prl_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [prl_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  output prl_pkg::cfg_t                   cfg_o
);

  prl_pkg::cfg_t    cfg_q, cfg_d;
  prl_pkg::reg_idx_e sel;
  logic             wr_en;

  // word select and write strobe
  assign sel    = prl_pkg::reg_idx_e'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (sel)
        prl_pkg::REG_ACTIVE_LOW:  cfg_d.active_low  = pwdata[prl_pkg::STATUS_W-1:0];
        prl_pkg::REG_ACTIVE_HIGH: cfg_d.active_high = pwdata[prl_pkg::STATUS_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_low  <= prl_pkg::ACTIVE_LOW_RST;
      cfg_q.active_high <= prl_pkg::ACTIVE_HIGH_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read mux
  always_comb begin
    case (sel)
      prl_pkg::REG_ACTIVE_LOW:
        prdata = {{(prl_pkg::APB_DATA_W-prl_pkg::STATUS_W){1'b0}}, cfg_q.active_low};
      prl_pkg::REG_ACTIVE_HIGH:
        prdata = {{(prl_pkg::APB_DATA_W-prl_pkg::STATUS_W){1'b0}}, cfg_q.active_high};
      default: prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/core/prl_store.sv
// prl_store: slot memory, one write and one registered read port
// holds {status, payload} per slot; no package dependency
module prl_store #(
  parameter int SLOTS  = 64,
  parameter int DATA_W = 80
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(SLOTS)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(SLOTS)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem [SLOTS];
  logic [DATA_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, registered output
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/prl_ctrl.sv
// prl_ctrl: sequencer for the ring log; keeps oldest and end pointers,
// drives the slot memory and forms each result; depends on prl_pkg
module prl_ctrl #(
  parameter int SLOTS        = prl_pkg::DEF_SLOTS,
  parameter int PAYLOAD_BITS = prl_pkg::DEF_PAYLOAD_BITS,
  localparam int SLOT_W      = $clog2(SLOTS),
  localparam int DATA_W      = prl_pkg::STATUS_W + PAYLOAD_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  prl_pkg::cfg_t                 cfg_i,
  input  logic                          start_i,
  input  logic [prl_pkg::MODE_W-1:0]    mode_i,
  input  logic [prl_pkg::STATUS_W-1:0]  entry_status_i,
  input  logic [PAYLOAD_BITS-1:0]       entry_payload_i,
  input  logic [prl_pkg::IDX_W-1:0]     index_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic [prl_pkg::STATUS_W-1:0]  out_status_o,
  output logic [PAYLOAD_BITS-1:0]       out_payload_o,
  output logic [prl_pkg::CNT_W-1:0]     used_count_o,
  output logic                          error_o,
  output logic                          mem_we_o,
  output logic [SLOT_W-1:0]             mem_waddr_o,
  output logic [DATA_W-1:0]             mem_wdata_o,
  output logic                          mem_re_o,
  output logic [SLOT_W-1:0]             mem_raddr_o,
  input  logic [DATA_W-1:0]             mem_rdata_i
);

  localparam int UW = (SLOT_W > prl_pkg::CNT_W) ? SLOT_W : prl_pkg::CNT_W;
  localparam int IW = (SLOT_W + 1 > prl_pkg::IDX_W) ? SLOT_W + 1 : prl_pkg::IDX_W;
  localparam int IDX_N = 2 ** prl_pkg::IDX_W;
  localparam logic [SLOT_W-1:0] LAST = SLOT_W'(SLOTS - 1);

  prl_pkg::ctrl_state_e state_q, state_d;
  prl_pkg::scan_phase_e ph_q, ph_d;
  prl_pkg::mode_e       mode;

  logic [SLOT_W-1:0] oldest_q, oldest_d;
  logic [SLOT_W-1:0] end_q, end_d;
  logic [SLOT_W-1:0] scan_q, scan_d;
  logic [SLOT_W-1:0] f1_q, f1_d;
  logic [SLOT_W-1:0] f2_q, f2_d;
  logic [SLOT_W-1:0] rtag_q;
  logic              rv_q;
  logic              head_q, head_d;
  logic              err_pend_q, err_pend_d;

  logic                         done_q, done_d;
  logic [prl_pkg::STATUS_W-1:0] ost_q, ost_d;
  logic [PAYLOAD_BITS-1:0]      opl_q, opl_d;
  logic [prl_pkg::CNT_W-1:0]    used_q, used_d;
  logic                         err_q, err_d;

  logic [SLOT_W-1:0]             idx_mod_tbl [IDX_N];
  logic [SLOT_W:0]               rd_sum;
  logic [SLOT_W-1:0]             rd_slot;
  logic [UW-1:0]                 idx_u;
  logic [UW-1:0]                 used_now;
  logic [UW-1:0]                 used_app;
  logic [UW-1:0]                 used_scan;
  logic [IW-1:0]                 idx_i;
  logic                          idx_ok;
  logic [prl_pkg::STATUS_W-1:0]  rd_status;
  logic [PAYLOAD_BITS-1:0]       rd_payload;
  logic                          act;
  logic [SLOT_W-1:0]             f1_v, f2_v, scan_end, scan_old;
  logic [SLOT_W-1:0]             old_inc;

  // wrap helpers
  function automatic logic [SLOT_W-1:0] inc(logic [SLOT_W-1:0] s);
    return (s == LAST) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [SLOT_W-1:0] dec(logic [SLOT_W-1:0] s);
    return (s == '0) ? LAST : s - 1'b1;
  endfunction

  // entries between oldest and end, widened
  function automatic logic [UW-1:0] used_slots(logic [SLOT_W-1:0] e, logic [SLOT_W-1:0] o);
    logic [SLOT_W:0] t;
    t = {1'b0, e} - {1'b0, o};
    if (e < o) begin
      t = t + (SLOT_W+1)'(SLOTS);
    end
    return UW'(t[SLOT_W-1:0]);
  endfunction

  // index reduced modulo slot count, constant table
  for (genvar g = 0; g < IDX_N; g++) begin : g_mod
    assign idx_mod_tbl[g] = SLOT_W'(g % SLOTS);
  end

  // nth oldest slot
  assign rd_sum  = {1'b0, oldest_q} + {1'b0, idx_mod_tbl[index_i]};
  assign rd_slot = (rd_sum >= (SLOT_W+1)'(SLOTS)) ? SLOT_W'(rd_sum - (SLOT_W+1)'(SLOTS))
                                                  : rd_sum[SLOT_W-1:0];

  assign idx_u    = UW'(index_i);
  assign idx_i    = IW'(index_i);
  assign idx_ok   = idx_i < IW'(SLOTS);
  assign used_now = used_slots(end_q, oldest_q);

  assign rd_status  = mem_rdata_i[DATA_W-1 -: prl_pkg::STATUS_W];
  assign rd_payload = mem_rdata_i[PAYLOAD_BITS-1:0];
  assign act        = prl_pkg::slot_active(rd_status, cfg_i);
  assign mode       = prl_pkg::mode_e'(mode_i);
  assign old_inc    = (end_q == oldest_q) ? inc(oldest_q) : oldest_q;

  // scan outcome: an unfound search gives slot zero
  assign f1_v     = (ph_q == prl_pkg::PH_SECOND || ph_q == prl_pkg::PH_DONE) ? f1_q : '0;
  assign f2_v     = (ph_q == prl_pkg::PH_DONE) ? f2_q : '0;
  assign scan_end = head_q ? f1_v : f2_v;
  assign scan_old = head_q ? f2_v : f1_v;

  // used counts after an append and after a recover
  assign used_app  = used_slots(end_q, old_inc);
  assign used_scan = used_slots(scan_end, scan_old);

  // next state, memory requests and result
  always_comb begin
    state_d    = state_q;
    ph_d       = ph_q;
    oldest_d   = oldest_q;
    end_d      = end_q;
    scan_d     = scan_q;
    f1_d       = f1_q;
    f2_d       = f2_q;
    head_d     = head_q;
    err_pend_d = err_pend_q;
    done_d     = 1'b0;
    ost_d      = ost_q;
    opl_d      = opl_q;
    used_d     = used_q;
    err_d      = err_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;

    // evaluate scanned slot in the cycle after its read
    if (rv_q) begin
      case (ph_q)
        prl_pkg::PH_HEAD: begin
          head_d = act;
          ph_d   = prl_pkg::PH_FIRST;
        end
        prl_pkg::PH_FIRST: begin
          if (head_q ? !act : act) begin
            f1_d = rtag_q;
            ph_d = prl_pkg::PH_SECOND;
          end
        end
        prl_pkg::PH_SECOND: begin
          if (head_q ? act : !act) begin
            f2_d = rtag_q;
            ph_d = prl_pkg::PH_DONE;
          end
        end
        default: ph_d = ph_q;
      endcase
    end

    case (state_q)
      prl_pkg::ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = scan_q;
        if (scan_q == LAST) begin
          scan_d  = '0;
          state_d = prl_pkg::ST_IDLE;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      prl_pkg::ST_IDLE: begin
        if (start_i) begin
          case (mode)
            prl_pkg::MODE_RECOVER: begin
              scan_d  = '0;
              ph_d    = prl_pkg::PH_HEAD;
              state_d = prl_pkg::ST_SCAN;
            end
            prl_pkg::MODE_APPEND: begin
              mem_we_o    = 1'b1;
              mem_waddr_o = end_q;
              mem_wdata_o = {entry_status_i, entry_payload_i};
              end_d       = inc(end_q);
              state_d     = prl_pkg::ST_APPEND2;
            end
            prl_pkg::MODE_OVERWRITE: begin
              mem_we_o    = 1'b1;
              mem_waddr_o = dec(end_q);
              mem_wdata_o = {entry_status_i, entry_payload_i};
              done_d      = 1'b1;
              ost_d       = '0;
              opl_d       = '0;
              err_d       = 1'b0;
              used_d      = used_now[prl_pkg::CNT_W-1:0];
            end
            prl_pkg::MODE_READ: begin
              mem_re_o    = 1'b1;
              mem_raddr_o = rd_slot;
              err_pend_d  = idx_u >= used_now;
              state_d     = prl_pkg::ST_RDWAIT;
            end
            prl_pkg::MODE_WRITE: begin
              mem_we_o    = idx_ok;
              mem_waddr_o = idx_i[SLOT_W-1:0];
              mem_wdata_o = {entry_status_i, entry_payload_i};
              done_d      = 1'b1;
              ost_d       = '0;
              opl_d       = '0;
              err_d       = 1'b0;
              used_d      = used_now[prl_pkg::CNT_W-1:0];
            end
            default: begin
              done_d = 1'b1;
              ost_d  = '0;
              opl_d  = '0;
              err_d  = 1'b0;
              used_d = used_now[prl_pkg::CNT_W-1:0];
            end
          endcase
        end
      end
      prl_pkg::ST_APPEND2: begin
        // clear the new end marker, drop the oldest when full
        mem_we_o    = 1'b1;
        mem_waddr_o = end_q;
        oldest_d    = old_inc;
        done_d      = 1'b1;
        ost_d       = '0;
        opl_d       = '0;
        err_d       = 1'b0;
        used_d      = used_app[prl_pkg::CNT_W-1:0];
        state_d     = prl_pkg::ST_IDLE;
      end
      prl_pkg::ST_RDWAIT: begin
        done_d  = 1'b1;
        ost_d   = rd_status;
        opl_d   = rd_payload;
        err_d   = err_pend_q;
        used_d  = used_now[prl_pkg::CNT_W-1:0];
        state_d = prl_pkg::ST_IDLE;
      end
      prl_pkg::ST_SCAN: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = scan_q;
        if (scan_q == LAST) begin
          scan_d  = '0;
          state_d = prl_pkg::ST_SCANLAST;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      prl_pkg::ST_SCANLAST: begin
        state_d = prl_pkg::ST_SCANFIN;
      end
      prl_pkg::ST_SCANFIN: begin
        oldest_d = scan_old;
        end_d    = scan_end;
        done_d   = 1'b1;
        ost_d    = '0;
        opl_d    = '0;
        err_d    = 1'b0;
        used_d   = used_scan[prl_pkg::CNT_W-1:0];
        state_d  = prl_pkg::ST_IDLE;
      end
      default: state_d = prl_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= prl_pkg::ST_CLEAR;
      ph_q     <= prl_pkg::PH_HEAD;
      oldest_q <= '0;
      end_q    <= '0;
      scan_q   <= '0;
      rv_q     <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      ph_q     <= ph_d;
      oldest_q <= oldest_d;
      end_q    <= end_d;
      scan_q   <= scan_d;
      rv_q     <= (state_q == prl_pkg::ST_SCAN);
      done_q   <= done_d;
    end
  end

  // payload and scan bookkeeping registers
  always_ff @(posedge clk_i) begin
    rtag_q     <= scan_q;
    f1_q       <= f1_d;
    f2_q       <= f2_d;
    head_q     <= head_d;
    err_pend_q <= err_pend_d;
    ost_q      <= ost_d;
    opl_q      <= opl_d;
    used_q     <= used_d;
    err_q      <= err_d;
  end

  assign busy_o        = (state_q != prl_pkg::ST_IDLE);
  assign done_o        = done_q;
  assign out_status_o  = ost_q;
  assign out_payload_o = opl_q;
  assign used_count_o  = used_q;
  assign error_o       = err_q;

endmodule

FILE: rtl/core/persistent_ring_log.sv
// persistent_ring_log: top level of the circular log with end marker
// depends on prl_pkg, prl_regs, prl_store and prl_ctrl
//
// Usage
// - a command beat is taken at a rising edge with start_i high and busy_o low;
//   mode_i picks recover, append, overwrite newest, read nth oldest or
//   direct slot write, with entry_status_i, entry_payload_i and index_i
// - every command gives one result: done_o is high for one cycle with
//   out_status_o, out_payload_o, used_count_o and error_o; the receiver
//   cannot hold it off, the result registers keep their value afterwards
// - overwrite, direct write and unused modes give their result in the cycle
//   after accept; append makes two slot writes through the single memory
//   write port; read goes through the registered memory read; recover
//   reads one slot per cycle over the whole store
// - one command at a time; busy_o stays high until its result is formed
// - the active window registers sit on an APB-style port at byte 0 and 4,
//   pready is always high; write them only while no command is in flight
// - after reset busy_o stays high while a clearing pass zeroes every slot;
//   register writes are taken during that pass
module persistent_ring_log #(
  parameter int SLOTS        = prl_pkg::DEF_SLOTS,
  parameter int PAYLOAD_BITS = prl_pkg::DEF_PAYLOAD_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [prl_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [prl_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [prl_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [prl_pkg::MODE_W-1:0]      mode_i,
  input  logic [prl_pkg::STATUS_W-1:0]    entry_status_i,
  input  logic [PAYLOAD_BITS-1:0]         entry_payload_i,
  input  logic [prl_pkg::IDX_W-1:0]       index_i,
  output logic                            done_o,
  output logic [prl_pkg::STATUS_W-1:0]    out_status_o,
  output logic [PAYLOAD_BITS-1:0]         out_payload_o,
  output logic [prl_pkg::CNT_W-1:0]       used_count_o,
  output logic                            error_o
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int DATA_W = prl_pkg::STATUS_W + PAYLOAD_BITS;

  prl_pkg::cfg_t     cfg;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [SLOT_W-1:0] mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  // configuration registers
  prl_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // slot memory
  prl_store #(
    .SLOTS  (SLOTS),
    .DATA_W (DATA_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // sequencer
  prl_ctrl #(
    .SLOTS        (SLOTS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .start_i         (start_i),
    .mode_i          (mode_i),
    .entry_status_i  (entry_status_i),
    .entry_payload_i (entry_payload_i),
    .index_i         (index_i),
    .busy_o          (busy_o),
    .done_o          (done_o),
    .out_status_o    (out_status_o),
    .out_payload_o   (out_payload_o),
    .used_count_o    (used_count_o),
    .error_o         (error_o),
    .mem_we_o        (mem_we),
    .mem_waddr_o     (mem_waddr),
    .mem_wdata_o     (mem_wdata),
    .mem_re_o        (mem_re),
    .mem_raddr_o     (mem_raddr),
    .mem_rdata_i     (mem_rdata)
  );

  // a result only follows an accepted beat or a command in flight
  a_done_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i || busy_o))
    else $error("result without a command");

  // memory is left alone while idle and no beat arrives
  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy_o && !start_i) |-> !mem_we)
    else $error("slot write while idle");

  // an error result comes only from an accepted read command
  a_error_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && error_o) |->
      ($past(start_i && !busy_o, 2) && ($past(mode_i, 2) == prl_pkg::MODE_READ)))
    else $error("error flag outside a read");

endmodule
